// ===== hw/rtl/lil_pkg.sv =====
`timescale 1ns / 1ps
package lil_pkg;

  localparam int MODEL_DEPTH = 1024;
  localparam int KEY_DEPTH   = 65536;
  localparam int POS_SHIFT   = 3;
  localparam int WINDOW_PAD  = 2;
  localparam int FIFO_DEPTH  = 4;

  localparam int MODEL_AW = $clog2(MODEL_DEPTH);
  localparam int KEY_AW   = $clog2(KEY_DEPTH);
  localparam int FIFO_AW  = $clog2(FIFO_DEPTH);

  localparam logic [1:0] CMD_LOOKUP     = 2'd0;
  localparam logic [1:0] CMD_LOAD_MODEL = 2'd1;
  localparam logic [1:0] CMD_LOAD_KEY   = 2'd2;
  localparam logic [1:0] CMD_NONE       = 2'd3;

  localparam logic [2:0] REG_MODEL_FIRST = 3'd0;
  localparam logic [2:0] REG_MODEL_END   = 3'd1;
  localparam logic [2:0] REG_EPSILON     = 3'd2;
  localparam logic [2:0] REG_KEY_COUNT   = 3'd3;
  localparam logic [2:0] REG_BASE_POS    = 3'd4;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [15:0]        index;
    logic [63:0]        key;
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
  } item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] position;
  } result_t;

  typedef struct packed {
    logic [9:0]  model_first;
    logic [10:0] model_end;
    logic [15:0] epsilon;
    logic [16:0] key_count;
    logic [28:0] base_pos;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_MPROBE, S_MCMP, S_MSEL, S_MGET, S_MUL, S_PRED,
    S_CAPW, S_WINIT, S_WPROBE, S_WCMP, S_CHK, S_C1, S_C2, S_DONE
  } state_t;

endpackage

// ===== hw/rtl/lil_front.sv =====
`timescale 1ns / 1ps
module lil_front (
  input  logic                  start,
  input  lil_pkg::item_t        item,
  input  lil_pkg::fifo_stat_t   stat,
  output logic                  busy,
  output logic                  push,
  output lil_pkg::item_t        push_item
);

  // drop unknown commands here so the back end never sees them
  assign busy      = stat.full;
  assign push      = start && !stat.full && (item.cmd != lil_pkg::CMD_NONE);
  assign push_item = item;

endmodule

// ===== hw/rtl/lil_fifo.sv =====
`timescale 1ns / 1ps
module lil_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lil_pkg::item_t      push_item,
  input  logic                pop,
  output lil_pkg::item_t      head,
  output lil_pkg::fifo_stat_t stat
);

  lil_pkg::item_t                mem [lil_pkg::FIFO_DEPTH];
  logic [lil_pkg::FIFO_AW-1:0]   wptr;
  logic [lil_pkg::FIFO_AW-1:0]   rptr;
  logic [lil_pkg::FIFO_AW:0]     count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      count <= count + (lil_pkg::FIFO_AW+1)'(push) - (lil_pkg::FIFO_AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_item;
  end

  assign head       = mem[rptr];
  assign stat.full  = (count == (lil_pkg::FIFO_AW+1)'(lil_pkg::FIFO_DEPTH));
  assign stat.empty = (count == '0);

endmodule

// ===== hw/rtl/lil_back.sv =====
`timescale 1ns / 1ps
module lil_back (
  input  logic                clk,
  input  logic                rst,
  input  lil_pkg::cfg_t       cfg,
  input  lil_pkg::item_t      head,
  input  lil_pkg::fifo_stat_t stat,
  output logic                pop,
  output logic                done,
  output lil_pkg::result_t    result
);

  lil_pkg::state_t state, state_next;
  lil_pkg::item_t  cur;

  logic [127:0] model_mem [lil_pkg::MODEL_DEPTH];
  logic [63:0]  key_mem   [lil_pkg::KEY_DEPTH];
  logic [127:0] mdata;
  logic [63:0]  kdata;
  logic [lil_pkg::MODEL_AW-1:0] maddr;
  logic [lil_pkg::KEY_AW-1:0]   kaddr;
  logic mwe, kwe;

  logic [10:0] ml, mr, hi, mid_m;
  logic [63:0] diff, mkey, msum;
  logic signed [31:0] slope_r, icpt_r, pred, sc, mic;
  logic [31:0] mag;
  logic [63:0] p1;
  logic [47:0] p2;
  logic big;
  logic signed [33:0] psum, ssum;
  logic signed [32:0] dw;
  logic [31:0] l32, wl;
  logic [16:0] wr, wr_new, lw, mid_k;
  logic [63:0] k0;
  logic [29:0] pacc;
  logic lookup_ok;

  assign hi    = (cfg.model_end != '0) ? cfg.model_end - 11'd1 : 11'd0;
  assign mid_m = ml + ((mr - ml) >> 1);
  assign mkey  = mdata[127:64];
  assign mic   = mdata[31:0];
  assign msum  = p1 + {32'b0, p2[47:16]};
  assign lw    = l32[16:0];
  assign mid_k = lw + ((wr - lw) >> 1);
  assign lookup_ok = (cfg.key_count != '0) && (l32 != '0)
                     && (l32 <= {15'b0, cfg.key_count} - 32'd1);

  always_comb begin
    if (slope_r == '0) sc = '0;
    else if (big) sc = slope_r[31] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else if (!slope_r[31]) sc = (msum > 64'h7fff_ffff) ? 32'sh7fff_ffff : signed'(msum[31:0]);
    else sc = (msum > 64'h8000_0000) ? 32'sh8000_0000 : signed'(-msum[31:0]);
  end

  assign psum = 34'(sc) + 34'(icpt_r);
  assign dw   = 33'(pred) - signed'({17'b0, cfg.epsilon});
  assign wl   = (pred > signed'({16'b0, cfg.epsilon})) ? dw[31:0] : 32'd0;
  assign ssum = 34'(pred) + signed'({18'b0, cfg.epsilon})
                + 34'(lil_pkg::WINDOW_PAD);
  assign wr_new = (ssum < 0 || ssum >= signed'({17'b0, cfg.key_count}))
                  ? cfg.key_count : ssum[16:0];

  always_ff @(posedge clk) begin
    if (mwe) model_mem[cur.index[lil_pkg::MODEL_AW-1:0]] <= {cur.key, cur.slope, cur.intercept};
    if (kwe) key_mem[cur.index[lil_pkg::KEY_AW-1:0]] <= cur.key;
    mdata <= model_mem[maddr];
    kdata <= key_mem[kaddr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= lil_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      lil_pkg::S_IDLE:   if (!stat.empty) state_next = lil_pkg::S_EXEC;
      lil_pkg::S_EXEC:   state_next = (cur.cmd == lil_pkg::CMD_LOOKUP) ? lil_pkg::S_MPROBE
                                                                      : lil_pkg::S_IDLE;
      lil_pkg::S_MPROBE: state_next = (ml < mr) ? lil_pkg::S_MCMP : lil_pkg::S_MSEL;
      lil_pkg::S_MCMP:   state_next = lil_pkg::S_MPROBE;
      lil_pkg::S_MSEL:   state_next = lil_pkg::S_MGET;
      lil_pkg::S_MGET:   state_next = lil_pkg::S_MUL;
      lil_pkg::S_MUL:    state_next = lil_pkg::S_PRED;
      lil_pkg::S_PRED:   state_next = lil_pkg::S_CAPW;
      lil_pkg::S_CAPW:   state_next = lil_pkg::S_WINIT;
      lil_pkg::S_WINIT:  state_next = lil_pkg::S_WPROBE;
      lil_pkg::S_WPROBE: state_next = (l32 < {15'b0, wr}) ? lil_pkg::S_WCMP : lil_pkg::S_CHK;
      lil_pkg::S_WCMP:   state_next = lil_pkg::S_WPROBE;
      lil_pkg::S_CHK:    state_next = lookup_ok ? lil_pkg::S_C1 : lil_pkg::S_DONE;
      lil_pkg::S_C1:     state_next = lil_pkg::S_C2;
      lil_pkg::S_C2:     state_next = lil_pkg::S_DONE;
      lil_pkg::S_DONE:   state_next = lil_pkg::S_IDLE;
      default:           state_next = lil_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    pop   = 1'b0;
    mwe   = 1'b0;
    kwe   = 1'b0;
    done  = 1'b0;
    maddr = ml[lil_pkg::MODEL_AW-1:0];
    kaddr = l32[lil_pkg::KEY_AW-1:0];
    case (state)
      lil_pkg::S_IDLE:   pop = !stat.empty;
      lil_pkg::S_EXEC: begin
        mwe = (cur.cmd == lil_pkg::CMD_LOAD_MODEL)
              && ({1'b0, cur.index} < 17'(lil_pkg::MODEL_DEPTH));
        kwe = (cur.cmd == lil_pkg::CMD_LOAD_KEY)
              && ({1'b0, cur.index} < 17'(lil_pkg::KEY_DEPTH));
      end
      lil_pkg::S_MPROBE: maddr = mid_m[lil_pkg::MODEL_AW-1:0];
      lil_pkg::S_MSEL: begin
        maddr = (ml > {1'b0, cfg.model_first}) ? 10'(ml - 11'd1) : cfg.model_first;
      end
      lil_pkg::S_WPROBE: kaddr = mid_k[lil_pkg::KEY_AW-1:0];
      lil_pkg::S_CHK:    kaddr = 16'(l32[15:0] - 16'd1);
      lil_pkg::S_DONE:   done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      lil_pkg::S_IDLE: cur <= head;
      lil_pkg::S_EXEC: begin
        ml <= {1'b0, cfg.model_first};
        mr <= hi;
      end
      lil_pkg::S_MCMP: begin
        if (mkey <= cur.key) ml <= mid_m + 11'd1;
        else                 mr <= mid_m;
      end
      lil_pkg::S_MGET: begin
        diff    <= (cur.key >= mkey) ? cur.key - mkey : 64'd0;
        slope_r <= mdata[63:32];
        icpt_r  <= mic;
      end
      lil_pkg::S_MUL: begin
        p1  <= 64'(mag) * 64'(diff[47:16]);
        p2  <= 48'(mag) * 48'(diff[15:0]);
        big <= (diff[63:48] != '0);
      end
      lil_pkg::S_PRED: begin
        if (psum > 34'sh7fff_ffff)       pred <= 32'sh7fff_ffff;
        else if (psum < -34'sh8000_0000) pred <= 32'sh8000_0000;
        else                             pred <= psum[31:0];
      end
      lil_pkg::S_CAPW: if (ml < hi && mic < pred) pred <= mic;
      lil_pkg::S_WINIT: begin
        l32 <= wl;
        wr  <= wr_new;
      end
      lil_pkg::S_WCMP: begin
        if (kdata <= cur.key) l32 <= {15'b0, mid_k + 17'd1};
        else                  wr  <= mid_k;
      end
      lil_pkg::S_CHK: if (!lookup_ok) result <= '0;
      lil_pkg::S_C1:  k0 <= kdata;
      lil_pkg::S_C2: begin
        if ((k0 <= cur.key && kdata > cur.key)
            || l32 == {15'b0, cfg.key_count} - 32'd1) begin
          result.found    <= 1'b1;
          result.position <= 32'({2'b0, pacc} << lil_pkg::POS_SHIFT);
        end else begin
          result <= '0;
        end
      end
      default: ;
    endcase
  end

  assign mag  = slope_r[31] ? 32'(-slope_r) : 32'(slope_r);
  assign pacc = {14'b0, 16'(l32[15:0] - 16'd1)} + {1'b0, cfg.base_pos};

endmodule

// ===== hw/rtl/learned_index_lookup_unit.sv =====
`timescale 1ns / 1ps
// Learned-index point lookup.
// Commands enter on item when start is high and busy is low. Load-model
// and load-key commands fill the segment table and the sorted key store
// and give no result; a lookup gives one result on result, marked by done
// for a single cycle. The receiver cannot stall, so results are never held.
// Accepted commands queue four deep in front of the execution engine;
// busy rises only while that queue is full, and unknown commands are dropped.
// The engine takes one command at a time. A lookup runs a binary search
// over the segment table, then one over the key window around the
// predicted position; each probe is one registered read of a store
// followed by a compare.
// Registers sit on the APB port at 4*i: model_first, model_end, epsilon,
// key_count, base_pos; write them only while the unit is idle.
// Reset (rst, synchronous) empties the queue, returns the engine to idle
// and sets model_end to 1 and the other registers to 0. Stores are not
// cleared and must be written before use.
module learned_index_lookup_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  lil_pkg::item_t    item,
  output logic              done,
  output lil_pkg::result_t  result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  lil_pkg::cfg_t       cfg;
  lil_pkg::fifo_stat_t stat;
  lil_pkg::item_t      push_item, head;
  logic push, pop;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.model_first <= '0;
      cfg.model_end   <= 11'd1;
      cfg.epsilon     <= '0;
      cfg.key_count   <= '0;
      cfg.base_pos    <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        lil_pkg::REG_MODEL_FIRST: cfg.model_first <= pwdata[9:0];
        lil_pkg::REG_MODEL_END:   cfg.model_end   <= pwdata[10:0];
        lil_pkg::REG_EPSILON:     cfg.epsilon     <= pwdata[15:0];
        lil_pkg::REG_KEY_COUNT:   cfg.key_count   <= pwdata[16:0];
        lil_pkg::REG_BASE_POS:    cfg.base_pos    <= pwdata[28:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      lil_pkg::REG_MODEL_FIRST: prdata = {22'b0, cfg.model_first};
      lil_pkg::REG_MODEL_END:   prdata = {21'b0, cfg.model_end};
      lil_pkg::REG_EPSILON:     prdata = {16'b0, cfg.epsilon};
      lil_pkg::REG_KEY_COUNT:   prdata = {15'b0, cfg.key_count};
      lil_pkg::REG_BASE_POS:    prdata = {3'b0, cfg.base_pos};
      default:                  prdata = '0;
    endcase
  end

  lil_front u_front (
    .start(start), .item(item), .stat(stat),
    .busy(busy), .push(push), .push_item(push_item)
  );

  lil_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .push_item(push_item),
    .pop(pop), .head(head), .stat(stat)
  );

  lil_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .head(head), .stat(stat),
    .pop(pop), .done(done), .result(result)
  );

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !stat.full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !stat.empty)
    else $error("queue read while empty");
`endif

endmodule

// ===== bench/learned_index_lookup_unit_tb.sv =====
`timescale 1ns / 1ps
module learned_index_lookup_unit_tb;

  localparam longint SAT_MAX = 64'sd2147483647;
  localparam longint SAT_MIN = -64'sd2147483648;
  localparam logic [63:0] ALL_ONES = '1;
  localparam int DRAIN_CYCLES = 150;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [1:0]       cmd;
    logic [15:0]      idx;
    logic [63:0]      key;
    logic [31:0]      slope;
    logic [31:0]      icpt;
    logic             typed;
    lil_pkg::result_t want;
    logic [2:0]       rg;
    logic [31:0]      val;
  } row_t;

  typedef struct {
    logic [63:0] key;
    logic [31:0] slope;
    logic [31:0] icpt;
  } segment_t;

  // Typed results are only where the key count is still zero after reset.
  localparam row_t DIR_TBL [25] = '{
    '{ROW_ITEM, lil_pkg::CMD_LOAD_MODEL, 16'd0, 64'd0, 32'd0, 32'd0, 1'b0, '0, 3'd0, 32'd0},
    '{ROW_ITEM, lil_pkg::CMD_LOOKUP, 16'd0, 64'd0, 32'd0, 32'd0, 1'b1, '0, 3'd0, 32'd0},
    '{ROW_ITEM, lil_pkg::CMD_LOOKUP, 16'hFFFF, ALL_ONES, 32'd0, 32'd0, 1'b1, '0, 3'd0,
      32'd0},
    '{ROW_ITEM, lil_pkg::CMD_LOAD_MODEL, 16'hFFFF, ALL_ONES, 32'h7FFFFFFF, 32'h80000000,
      1'b0, '0, 3'd0, 32'd0},
    '{ROW_ITEM, lil_pkg::CMD_LOAD_KEY, 16'hFFFF, ALL_ONES, 32'd0, 32'd0, 1'b0, '0, 3'd0,
      32'd0},
    '{ROW_ITEM, lil_pkg::CMD_NONE, 16'hFFFF, ALL_ONES, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0,
      '0, 3'd0, 32'd0},
    '{ROW_ITEM, lil_pkg::CMD_LOAD_KEY, 16'd0, 64'd100, 32'd0, 32'd0, 1'b0, '0, 3'd0, 32'd0},
    '{ROW_ITEM, lil_pkg::CMD_LOAD_KEY, 16'd1, 64'd200, 32'd0, 32'd0, 1'b0, '0, 3'd0, 32'd0},
    '{ROW_ITEM, lil_pkg::CMD_LOAD_KEY, 16'd2, 64'd300, 32'd0, 32'd0, 1'b0, '0, 3'd0, 32'd0},
    '{ROW_ITEM, lil_pkg::CMD_LOAD_KEY, 16'd3, 64'd400, 32'd0, 32'd0, 1'b0, '0, 3'd0, 32'd0},
    '{ROW_ITEM, lil_pkg::CMD_LOAD_MODEL, 16'd0, 64'd100, 32'd655, 32'd0, 1'b0, '0, 3'd0,
      32'd0},
    '{ROW_ITEM, lil_pkg::CMD_LOAD_MODEL, 16'd1, 64'd300, 32'd0, 32'd1, 1'b0, '0, 3'd0,
      32'd0},
    '{ROW_REG, lil_pkg::CMD_NONE, 16'd0, 64'd0, 32'd0, 32'd0, 1'b0, '0,
      lil_pkg::REG_KEY_COUNT, 32'd4},
    '{ROW_REG, lil_pkg::CMD_NONE, 16'd0, 64'd0, 32'd0, 32'd0, 1'b0, '0,
      lil_pkg::REG_EPSILON, 32'd1},
    '{ROW_REG, lil_pkg::CMD_NONE, 16'd0, 64'd0, 32'd0, 32'd0, 1'b0, '0,
      lil_pkg::REG_MODEL_END, 32'd3},
    '{ROW_REG, lil_pkg::CMD_NONE, 16'd0, 64'd0, 32'd0, 32'd0, 1'b0, '0,
      lil_pkg::REG_BASE_POS, 32'd536805375},
    '{ROW_ITEM, lil_pkg::CMD_LOOKUP, 16'd0, 64'd250, 32'd0, 32'd0, 1'b0, '0, 3'd0, 32'd0},
    '{ROW_ITEM, lil_pkg::CMD_LOOKUP, 16'd0, 64'd50, 32'd0, 32'd0, 1'b0, '0, 3'd0, 32'd0},
    '{ROW_ITEM, lil_pkg::CMD_LOOKUP, 16'd0, 64'd400, 32'd0, 32'd0, 1'b0, '0, 3'd0, 32'd0},
    '{ROW_ITEM, lil_pkg::CMD_LOOKUP, 16'd0, ALL_ONES, 32'd0, 32'd0, 1'b0, '0, 3'd0, 32'd0},
    '{ROW_ITEM, lil_pkg::CMD_LOAD_MODEL, 16'd0, 64'd100, 32'h80000000, 32'hFFFFFFFB, 1'b0,
      '0, 3'd0, 32'd0},
    '{ROW_ITEM, lil_pkg::CMD_LOOKUP, 16'd0, 64'd350, 32'd0, 32'd0, 1'b0, '0, 3'd0, 32'd0},
    '{ROW_ITEM, lil_pkg::CMD_LOAD_MODEL, 16'd0, 64'd100, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0,
      '0, 3'd0, 32'd0},
    '{ROW_ITEM, lil_pkg::CMD_LOOKUP, 16'd0, ALL_ONES, 32'd0, 32'd0, 1'b0, '0, 3'd0, 32'd0},
    '{ROW_ITEM, lil_pkg::CMD_LOOKUP, 16'd0, 64'd100, 32'd0, 32'd0, 1'b0, '0, 3'd0, 32'd0}
  };

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  lil_pkg::item_t   item;
  logic             done;
  lil_pkg::result_t result;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [4:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  // Shadow of the unit: registers and the entries written so far.
  logic [9:0]  cfg_first;
  logic [10:0] cfg_end;
  logic [15:0] cfg_eps;
  logic [16:0] cfg_kc;
  logic [28:0] cfg_sp;
  segment_t    seg_shadow [int];
  logic [63:0] key_shadow [int];

  lil_pkg::result_t lookup_answers [$];
  bit          start_high;
  int          idle_pct;
  int          errors;
  int          n_items;
  int          n_lookups;
  int          n_results;
  int          n_found;

  learned_index_lookup_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item), .done(done),
    .result(result), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d results outstanding", lookup_answers.size());
    $display("Verification failed");
    $finish;
  end

  task automatic note_mismatch(input string what, input lil_pkg::result_t want,
                               input lil_pkg::result_t got);
    errors++;
    if (errors <= 10)
      $display("%0t %s: expected found=%0b pos=%h, got found=%0b pos=%h", $realtime, what,
               want.found, want.position, got.found, got.position);
  endtask

  always @(posedge clk) begin
    lil_pkg::result_t want;
    if (!rst && done) begin
      n_results++;
      if (result.found === 1'b1) n_found++;
      if (lookup_answers.size() == 0) begin
        note_mismatch("unexpected result", '0, result);
      end else begin
        want = lookup_answers.pop_front();
        if (result.found !== want.found || result.position !== want.position)
          note_mismatch("result mismatch", want, result);
      end
    end
  end

  // Store reads; flag any that would touch an entry never written.
  function automatic segment_t seg_rd(input longint i, inout bit safe);
    segment_t z;
    z = '{64'd0, 32'd0, 32'd0};
    if (i >= lil_pkg::MODEL_DEPTH) return z;
    if (!seg_shadow.exists(int'(i))) begin
      safe = 1'b0;
      return z;
    end
    return seg_shadow[int'(i)];
  endfunction

  function automatic logic [63:0] key_rd(input longint i, inout bit safe);
    if (i >= lil_pkg::KEY_DEPTH || i < 0) return 64'd0;
    if (!key_shadow.exists(int'(i))) begin
      safe = 1'b0;
      return 64'd0;
    end
    return key_shadow[int'(i)];
  endfunction

  function automatic longint sat32(input longint v);
    if (v > SAT_MAX) return SAT_MAX;
    if (v < SAT_MIN) return SAT_MIN;
    return v;
  endfunction

  // Q16.16 slope times offset, truncated toward zero and saturated.
  function automatic longint slope_offset(input longint s, input logic [63:0] d);
    longint unsigned mag;
    longint unsigned m;
    if (s == 0 || d == 0) return 0;
    mag = (s < 0) ? longint'(-s) : longint'(s);
    if (d[63:48] != 0) return (s < 0) ? SAT_MIN : SAT_MAX;
    m = mag * (d >> 16) + ((mag * (d & 64'hFFFF)) >> 16);
    if (s > 0) return (m > longint'(SAT_MAX)) ? SAT_MAX : longint'(m);
    return (m > 64'd2147483648) ? SAT_MIN : -longint'(m);
  endfunction

  function automatic lil_pkg::result_t predict_lookup(input logic [63:0] q, output bit safe);
    longint   lo, hi_b, mid, seg, top, wl, wr, kc, pred, eps, s;
    segment_t sm, sn;
    logic [63:0] diff, k_lo, k_hi;
    lil_pkg::result_t r;
    safe = 1'b1;
    r = '0;
    top = (cfg_end > 0) ? longint'(cfg_end) - 1 : 0;
    lo = cfg_first;
    hi_b = top;
    while (lo < hi_b) begin
      mid = lo + (hi_b - lo) / 2;
      sm = seg_rd(mid, safe);
      if (sm.key <= q) lo = mid + 1;
      else hi_b = mid;
    end
    seg = (lo > cfg_first) ? lo - 1 : longint'(cfg_first);
    sm = seg_rd(seg, safe);
    diff = (q >= sm.key) ? q - sm.key : 64'd0;
    pred = sat32(slope_offset(longint'($signed(sm.slope)), diff) +
                 longint'($signed(sm.icpt)));
    if (lo < top) begin
      sn = seg_rd(lo, safe);
      if (longint'($signed(sn.icpt)) < pred) pred = longint'($signed(sn.icpt));
    end
    eps = cfg_eps;
    kc = cfg_kc;
    wl = (pred > eps) ? pred - eps : 0;
    s = pred + eps + lil_pkg::WINDOW_PAD;
    wr = (s < 0 || s >= kc) ? kc : s;
    lo = wl;
    hi_b = wr;
    while (lo < hi_b) begin
      mid = lo + (hi_b - lo) / 2;
      if (key_rd(mid, safe) <= q) lo = mid + 1;
      else hi_b = mid;
    end
    if (kc != 0 && lo != 0 && lo <= kc - 1) begin
      k_lo = key_rd(lo - 1, safe);
      k_hi = key_rd(lo, safe);
      if ((k_lo <= q && k_hi > q) || lo == kc - 1) begin
        r.found = 1'b1;
        r.position = 32'((lo - 1 + longint'(cfg_sp)) << lil_pkg::POS_SHIFT);
      end
    end
    return r;
  endfunction

  task automatic drop_start;
    if (start_high) start <= 1'b0;
    start_high = 1'b0;
  endtask

  // Present one transaction, hold it until accepted, then update the shadow.
  task automatic send_item(input lil_pkg::item_t it, input bit typed,
                           input lil_pkg::result_t want);
    bit safe;
    lil_pkg::result_t r;
    start <= 1'b1;
    item <= it;
    start_high = 1'b1;
    do @(posedge clk); while (busy === 1'b1);
    n_items++;
    case (it.cmd)
      lil_pkg::CMD_LOOKUP: begin
        r = predict_lookup(it.key, safe);
        lookup_answers.push_back(typed ? want : r);
        n_lookups++;
      end
      lil_pkg::CMD_LOAD_MODEL:
        if (it.index < lil_pkg::MODEL_DEPTH)
          seg_shadow[int'(it.index)] = '{it.key, it.slope, it.intercept};
      lil_pkg::CMD_LOAD_KEY: key_shadow[int'(it.index)] = it.key;
      default: ;
    endcase
    if ($urandom_range(99) < idle_pct) begin
      drop_start();
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Wait for the unit to go quiet: no results owed and loads retired.
  task automatic drain;
    drop_start();
    @(posedge clk);
    while (lookup_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] rg, input logic [31:0] val);
    logic [31:0] rd;
    logic [31:0] want;
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {rg, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    case (rg)
      lil_pkg::REG_MODEL_FIRST: begin cfg_first = val[9:0]; want = 32'(cfg_first); end
      lil_pkg::REG_MODEL_END:   begin cfg_end = val[10:0]; want = 32'(cfg_end); end
      lil_pkg::REG_EPSILON:     begin cfg_eps = val[15:0]; want = 32'(cfg_eps); end
      lil_pkg::REG_KEY_COUNT:   begin cfg_kc = val[16:0]; want = 32'(cfg_kc); end
      default:                  begin cfg_sp = val[28:0]; want = 32'(cfg_sp); end
    endcase
    // read back the register just written
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== want) begin
      errors++;
      if (errors <= 10)
        $display("%0t register %0d read back %h, expected %h", $realtime, rg, rd, want);
    end
    // leave the bus idle before the next transfer
    @(posedge clk);
  endtask

  // Fill keys and segments for one setting, then mix lookups with noise.
  task automatic run_phase(input logic [9:0] first, input logic [10:0] seg_end,
                           input logic [15:0] eps, input logic [16:0] kc,
                           input logic [28:0] sp, input int nk, input bit spread,
                           input int n_rand);
    logic [63:0] keys [$];
    logic [63:0] base, stride, q, span;
    longint      slope_v;
    lil_pkg::item_t   it;
    lil_pkg::result_t r;
    bit          safe;
    int          nseg, j, a, b, pick, tries;
    drain();
    reg_write(lil_pkg::REG_MODEL_FIRST, 32'(first));
    reg_write(lil_pkg::REG_MODEL_END, 32'(seg_end));
    reg_write(lil_pkg::REG_EPSILON, 32'(eps));
    reg_write(lil_pkg::REG_KEY_COUNT, 32'(kc));
    reg_write(lil_pkg::REG_BASE_POS, 32'(sp));
    stride = spread ? ALL_ONES / nk : 64'($urandom_range(1, 16));
    base = spread ? 64'd0 : {2'b00, $urandom, 30'($urandom)} >> $urandom_range(0, 40);
    for (j = 0; j < nk; j++) begin
      keys.push_back(base + stride * j + (spread ? 64'd0 : 64'($urandom_range(0, 0))));
      it = '{lil_pkg::CMD_LOAD_KEY, 16'(j), keys[j], 32'd0, 32'd0};
      send_item(it, 1'b0, '0);
    end
    nseg = (seg_end > first + 1) ? int'(seg_end) - int'(first) : 1;
    for (j = 0; j < nseg; j++) begin
      a = j * nk / nseg;
      b = (j + 1) * nk / nseg;
      if (b <= a) b = a + 1;
      if (b > nk) b = nk;
      span = keys[b - 1] - keys[a];
      slope_v = (span == 0) ? 0 : longint'((64'(b - a) << 16) / span);
      if (slope_v > SAT_MAX) slope_v = SAT_MAX;
      it = '{lil_pkg::CMD_LOAD_MODEL, 16'(int'(first) + j), keys[a], 32'(slope_v), 32'(a)};
      if ($urandom_range(7) == 0) begin
        it.slope = $urandom;
        it.intercept = $urandom_range(0, 3) == 0 ? $urandom : 32'(a + $urandom_range(0, 4) - 2);
      end
      send_item(it, 1'b0, '0);
    end
    for (j = 0; j < n_rand; j++) begin
      pick = $urandom_range(99);
      it = '{lil_pkg::CMD_LOOKUP, 16'($urandom), 64'd0, 32'($urandom), 32'($urandom)};
      if (pick < 6) begin
        it.cmd = lil_pkg::CMD_LOAD_KEY;
        it.index = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, nk - 1));
        it.key = $urandom_range(0, 1) ? {$urandom, $urandom} : keys[it.index % nk];
      end else if (pick < 10) begin
        it.cmd = lil_pkg::CMD_LOAD_MODEL;
        it.key = {$urandom, $urandom};
        // only rewrite a slot already in use, or one the unit ignores
        if ($urandom_range(0, 1)) it.index = 16'(int'(first) + $urandom_range(0, nseg - 1));
        else it.index = 16'($urandom_range(lil_pkg::MODEL_DEPTH, 65535));
      end else if (pick < 13) begin
        it.cmd = lil_pkg::CMD_NONE;
        it.key = {$urandom, $urandom};
      end else begin
        tries = 0;
        do begin
          case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: q = keys[$urandom_range(0, nk - 1)];
            6: q = keys[$urandom_range(0, nk - 1)] + 1;
            7: q = keys[$urandom_range(0, nk - 1)] - 1;
            8: q = {$urandom, $urandom};
            default: q = $urandom_range(0, 1) ? ALL_ONES : 64'd0;
          endcase
          r = predict_lookup(q, safe);
          tries++;
        end while (!safe && tries < 20);
        if (!safe) continue;
        it.key = q;
      end
      send_item(it, 1'b0, '0);
    end
  endtask

  initial begin
    row_t  row;
    lil_pkg::item_t it;
    rst <= 1'b1;
    start <= 1'b0;
    item <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    start_high = 1'b0;
    cfg_first = 0;
    cfg_end = 1;
    cfg_eps = 0;
    cfg_kc = 0;
    cfg_sp = 0;
    errors = 0;
    n_items = 0;
    n_lookups = 0;
    n_results = 0;
    n_found = 0;
    idle_pct = 16;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIR_TBL[i]) begin
      row = DIR_TBL[i];
      if (row.kind == ROW_REG) begin
        drain();
        reg_write(row.rg, row.val);
      end else begin
        it = '{row.cmd, row.idx, row.key, row.slope, row.icpt};
        send_item(it, row.typed, row.want);
      end
    end

    // sender idles 16%, then 51%, then never
    run_phase(10'($urandom_range(0, 1000)), 11'd0, 16'($urandom_range(0, 4)), 17'd0, 29'd0,
              1, 1'b0, 0);
    run_phase(10'($urandom_range(0, 900)), 11'd0, 16'd0, 17'd0, 29'd0, 1, 1'b0, 0);
    begin
      int f;
      f = $urandom_range(0, 1000);
      run_phase(10'(f), 11'(f + $urandom_range(1, 6)), 16'($urandom_range(0, 6)),
                17'($urandom_range(2, 40)), 29'($urandom), 1, 1'b0, 0);
    end
    // phase list: key_count comes from kc below, the number of keys written from nk
    run_phase(10'd1023, 11'd1024, 16'd65535, 17'd30, 29'd536805375, 30, 1'b0, 130);
    idle_pct = 51;
    run_phase(10'd5, 11'd0, 16'd0, 17'd65536, 29'd0, 50, 1'b0, 130);
    run_phase(10'd1010, 11'd1024, 16'($urandom_range(0, 8)), 17'd40, 29'($urandom), 40,
              1'b0, 130);
    idle_pct = 0;
    begin
      int f;
      int n;
      f = $urandom_range(0, 1000);
      n = $urandom_range(8, 40);
      run_phase(10'(f), 11'(f + $urandom_range(1, 8)), 16'($urandom_range(0, 3)), 17'(n),
                29'($urandom), n, 1'b1, 130);
      f = $urandom_range(0, 1000);
      n = $urandom_range(2, 40);
      run_phase(10'(f), 11'(f + $urandom_range(2, 8)), 16'($urandom_range(0, 16)), 17'(n),
                29'($urandom_range(0, 1000)), n, 1'b0, 130);
    end
    drain();

    $display("Sent %0d transactions, %0d lookups; %0d results checked, %0d found",
             n_items, n_lookups, n_results, n_found);
    $display("Covered register extremes, empty and full key counts, %0d mismatches", errors);
    if (errors == 0 && lookup_answers.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
